FILE: hdl/bhf_pkg.sv
// ----------------------------------------------------------------------------
// bhf_pkg: shared types and constants for the biquad high-pass filter
// Holds the item structs, coefficient set, sequencer steps, the 64-bit
// saturating add and the coefficient magnitude helper used by the datapath.
// ----------------------------------------------------------------------------
package bhf_pkg;

    // Default build values.
    localparam int DEF_COEF_FRAC_BITS = 30;
    localparam int DEF_STATE_WIDTH    = 48;

    // Fixed widths.
    localparam int COEF_W      = 32;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 64;
    localparam int PROD_W      = 64;
    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Register indexes on the configuration port.
    localparam cfg_index_t REG_COEF_B0 = 3'd0;
    localparam cfg_index_t REG_COEF_B1 = 3'd1;
    localparam cfg_index_t REG_COEF_B2 = 3'd2;
    localparam cfg_index_t REG_COEF_A1 = 3'd3;
    localparam cfg_index_t REG_COEF_A2 = 3'd4;

    // Coefficient values after reset (90 Hz Butterworth high-pass, Q2.30).
    localparam coef_t RST_COEF_B0 = 32'sd1047239728;
    localparam coef_t RST_COEF_B1 = -32'sd2094480530;
    localparam coef_t RST_COEF_B2 = 32'sd1047239728;
    localparam coef_t RST_COEF_A1 = -32'sd2093826622;
    localparam coef_t RST_COEF_A2 = 32'sd1021392615;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       clear_first;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } out_item_t;

    // Sequencer steps of the work on an item, in order.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B0,
        ST_Y,
        ST_N1_B,
        ST_N1_ALO,
        ST_N1_AHI,
        ST_N1_D,
        ST_N2_B,
        ST_N2_ALO,
        ST_N2_AHI,
        ST_PUSH
    } step_t;

    typedef struct packed {
        step_t step;
        logic  load;
        logic  push;
    } seq_ctrl_t;

    // Signed 64-bit add that saturates instead of wrapping.
    function automatic acc_t sat_add(acc_t a, acc_t b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // Magnitude of a coefficient; the most negative value maps to 2^31.
    function automatic logic [COEF_W-1:0] coef_mag(coef_t c);
        return c[COEF_W-1] ? COEF_W'(~c + 1'b1) : COEF_W'(c);
    endfunction

endpackage

FILE: hdl/bhf_mult.sv
// ----------------------------------------------------------------------------
// bhf_mult: shared unsigned multiplier
// One 32 x 32 unsigned multiply per enabled cycle, product registered. The
// product holds while the unit is not enabled.
// ----------------------------------------------------------------------------
module bhf_mult
    import bhf_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [COEF_W-1:0] op_a,
    input  logic [COEF_W-1:0] op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // Full-width product of the two magnitudes.
    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    // Product register, loaded only when a multiply is issued.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/bhf_seq.sv
// ----------------------------------------------------------------------------
// bhf_seq: step sequencer
// Walks one item through the multiply and accumulate steps and waits for
// room in the output register before returning to idle.
// ----------------------------------------------------------------------------
module bhf_seq
    import bhf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    output logic      in_ready,
    output seq_ctrl_t ctrl
);

    step_t state_reg;
    step_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and step outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl.step  = state_reg;
        ctrl.load  = 1'b0;
        ctrl.push  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_B0;
                end
            end
            ST_B0:     state_next = ST_Y;
            ST_Y:      state_next = ST_N1_B;
            ST_N1_B:   state_next = ST_N1_ALO;
            ST_N1_ALO: state_next = ST_N1_AHI;
            ST_N1_AHI: state_next = ST_N1_D;
            ST_N1_D:   state_next = ST_N2_B;
            ST_N2_B:   state_next = ST_N2_ALO;
            ST_N2_ALO: state_next = ST_N2_AHI;
            ST_N2_AHI: state_next = ST_PUSH;
            ST_PUSH:
            begin
                ctrl.push = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/bhf_datapath.sv
// ----------------------------------------------------------------------------
// bhf_datapath: biquad arithmetic around the shared multiplier
// Holds the sample, y, the accumulator and both delay states. The steps use
// multiplier products issued by earlier steps and issue the next multiply.
// ----------------------------------------------------------------------------
module bhf_datapath
    import bhf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int STATE_WIDTH    = DEF_STATE_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_ctrl_t ctrl,
    input  in_item_t  in_data,
    input  coef_set_t coefs,
    output out_item_t result
);

    localparam int                HI_SHIFT = COEF_W - COEF_FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] LIM      = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic [PROD_W-1:0] HI_LIMIT = LIM >> HI_SHIFT;
    localparam logic [SAMPLE_W-1:0] POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] NEG_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Saturate a 64-bit value to the signed delay state range.
    function automatic logic signed [STATE_WIDTH-1:0] clamp_state(acc_t v);
        logic [ACC_W-STATE_WIDTH:0] top;
        top = v[ACC_W-1:STATE_WIDTH-1];
        if ((&top) || !(|top))
        begin
            return v[STATE_WIDTH-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                          : {1'b0, {(STATE_WIDTH-1){1'b1}}};
    endfunction

    logic signed [SAMPLE_W-1:0]    x_reg;
    logic signed [STATE_WIDTH-1:0] y_reg;
    logic [ACC_W-1:0]              ymag_reg;
    acc_t                          acc_reg;
    logic [PROD_W-1:0]             lo_reg;
    logic signed [STATE_WIDTH-1:0] d1_reg;
    logic signed [STATE_WIDTH-1:0] d2_reg;
    out_item_t                     res_reg;

    logic signed [STATE_WIDTH-1:0] y_next;
    logic [ACC_W-1:0]              ymag_next;
    logic [PROD_W-1:0]             lo_next;
    logic signed [STATE_WIDTH-1:0] d1_next;
    logic signed [STATE_WIDTH-1:0] d2_next;
    out_item_t                     res_next;

    logic [SAMPLE_W-1:0] xmag;
    logic                mul_en;
    logic [COEF_W-1:0]   mul_a;
    logic [COEF_W-1:0]   mul_b;
    logic [PROD_W-1:0]   prod;

    coef_t             b_coef;
    coef_t             a_coef;
    acc_t              prod_sgn;
    acc_t              b_term;
    logic [PROD_W-1:0] hi_shifted;
    logic [PROD_W:0]   mag_sum;
    logic [PROD_W-1:0] a_mag;
    acc_t              a_sub;
    acc_t              a_acc;
    acc_t              y_sum;
    acc_t              n1_sum;
    acc_t              y_ext;
    logic [ACC_W-1:0]  y_round;
    logic              y_neg;

    assign xmag  = x_reg[SAMPLE_W-1] ? SAMPLE_W'(-x_reg) : SAMPLE_W'(x_reg);
    assign y_neg = y_reg[STATE_WIDTH-1];

    // Multiplier operand selection: each issuing step sets up the multiply that
    // a later step consumes.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (ctrl.step)
            ST_B0:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.b0);
                mul_b  = COEF_W'(xmag);
            end
            ST_Y:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.b1);
                mul_b  = COEF_W'(xmag);
            end
            ST_N1_B:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.a1);
                mul_b  = ymag_reg[COEF_W-1:0];
            end
            ST_N1_ALO:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.a1);
                mul_b  = ymag_reg[ACC_W-1:COEF_W];
            end
            ST_N1_AHI:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.b2);
                mul_b  = COEF_W'(xmag);
            end
            ST_N2_B:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.a2);
                mul_b  = ymag_reg[COEF_W-1:0];
            end
            ST_N2_ALO:
            begin
                mul_en = 1'b1;
                mul_a  = coef_mag(coefs.a2);
                mul_b  = ymag_reg[ACC_W-1:COEF_W];
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    bhf_mult u_mult (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Coefficients consumed by the current step.
    always_comb
    begin
        case (ctrl.step)
            ST_N1_B: b_coef = coefs.b1;
            ST_N2_B: b_coef = coefs.b2;
            default: b_coef = coefs.b0;
        endcase
        case (ctrl.step)
            ST_N2_AHI: a_coef = coefs.a2;
            default:   a_coef = coefs.a1;
        endcase
    end

    // Exact coefficient times sample, signed.
    assign prod_sgn = acc_t'(prod);
    assign b_term   = (b_coef[COEF_W-1] ^ x_reg[SAMPLE_W-1]) ? -prod_sgn : prod_sgn;

    // y = b0*x + delay_one, then its magnitude for the feedback multiplies.
    assign y_sum     = sat_add(b_term, ACC_W'(d1_reg));
    assign y_next    = clamp_state(y_sum);
    assign y_ext     = ACC_W'(y_next);
    assign ymag_next = y_next[STATE_WIDTH-1] ? ACC_W'(~y_ext + 1'b1) : ACC_W'(y_ext);

    // Feedback product rounding: low half plus a half LSB, then the high half
    // shifted into place, with the magnitude capped at 2^63-1.
    assign lo_next    = (prod + HALF) >> COEF_FRAC_BITS;
    assign hi_shifted = prod << HI_SHIFT;
    assign mag_sum    = (PROD_W+1)'(hi_shifted) + (PROD_W+1)'(lo_reg);
    assign a_mag      = ((prod > HI_LIMIT) || (mag_sum > (PROD_W+1)'(LIM)))
                        ? LIM : mag_sum[PROD_W-1:0];

    // The rounded a*y is subtracted from the accumulator.
    assign a_sub = (a_coef[COEF_W-1] ^ y_neg) ? acc_t'(a_mag) : -acc_t'(a_mag);
    assign a_acc = sat_add(acc_reg, a_sub);

    // New delay states.
    assign n1_sum  = sat_add(acc_reg, ACC_W'(d2_reg));
    assign d1_next = clamp_state(n1_sum);
    assign d2_next = clamp_state(a_acc);

    // Output sample: y rounded half away from zero, then saturated.
    assign y_round = (ymag_reg + HALF) >> COEF_FRAC_BITS;
    always_comb
    begin
        if (!y_neg && (y_round > ACC_W'(POS_MAX)))
        begin
            res_next.sample_out = POS_MAX;
            res_next.clipped    = 1'b1;
        end
        else if (y_neg && (y_round > ACC_W'(NEG_MIN)))
        begin
            res_next.sample_out = NEG_MIN;
            res_next.clipped    = 1'b1;
        end
        else
        begin
            res_next.sample_out = y_neg ? -y_round[SAMPLE_W-1:0] : y_round[SAMPLE_W-1:0];
            res_next.clipped    = 1'b0;
        end
    end

    // Delay states: cleared by reset or by the item's clear bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (ctrl.load && in_data.clear_first)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (ctrl.step == ST_N1_D)
        begin
            d1_reg <= d1_next;
        end
        else if (ctrl.step == ST_N2_AHI)
        begin
            d2_reg <= d2_next;
        end
    end

    // Working registers for the item in flight.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= in_data.sample_in;
        end
        case (ctrl.step)
            ST_Y:
            begin
                y_reg    <= y_next;
                ymag_reg <= ymag_next;
            end
            ST_N1_B, ST_N2_B:
            begin
                acc_reg <= b_term;
            end
            ST_N1_ALO, ST_N2_ALO:
            begin
                lo_reg <= lo_next;
            end
            ST_N1_AHI:
            begin
                acc_reg <= a_acc;
            end
            ST_N1_D:
            begin
                res_reg <= res_next;
            end
            default:
            begin
            end
        endcase
    end

    assign result = res_reg;

endmodule

FILE: hdl/biquad_highpass_filter.sv
// ----------------------------------------------------------------------------
// biquad_highpass_filter: second-order IIR, transposed direct form II
// Coefficient registers, output register and the sequencer and datapath.
// ----------------------------------------------------------------------------
// Each accepted item is one signed 16-bit sample and yields one filtered
// sample, rounded half away from zero and saturated, with a flag when it
// clipped. A new item is taken only once the last one is pushed out: one
// 32 x 32 multiplier is used seven times per sample (b0*x, b1*x, b2*x, and
// a1*y and a2*y split into two 32-bit halves of y), with the accumulations
// interleaved. The finished result sits in an output register, so the next
// item is taken while it waits; the block stalls only when a second result is
// done before the first is taken. Coefficients go through the plain write
// port and reset to a 90 Hz Butterworth high-pass for 16 kHz audio; the user
// must write them only while the block is idle; the block does not enforce it.
module biquad_highpass_filter
    import bhf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    parameter int STATE_WIDTH    = DEF_STATE_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_wen,
    input  cfg_index_t        cfg_index,
    input  logic [COEF_W-1:0] cfg_data
);

    coef_set_t coefs_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    seq_ctrl_t ctrl;
    out_item_t result;
    logic      out_free;

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= RST_COEF_B0;
            coefs_reg.b1 <= RST_COEF_B1;
            coefs_reg.b2 <= RST_COEF_B2;
            coefs_reg.a1 <= RST_COEF_A1;
            coefs_reg.a2 <= RST_COEF_A2;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_COEF_B0: coefs_reg.b0 <= coef_t'(cfg_data);
                REG_COEF_B1: coefs_reg.b1 <= coef_t'(cfg_data);
                REG_COEF_B2: coefs_reg.b2 <= coef_t'(cfg_data);
                REG_COEF_A1: coefs_reg.a1 <= coef_t'(cfg_data);
                REG_COEF_A2: coefs_reg.a2 <= coef_t'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    bhf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    bhf_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_WIDTH    (STATE_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .in_data (in_data),
        .coefs   (coefs_reg),
        .result  (result)
    );

    // Output item valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output item payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: bench/tb_biquad_highpass_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_highpass_filter: self-checking bench for the biquad high-pass
// Drives samples through the valid/ready input, writes coefficient sets on
// the write port while the filter is idle, and checks every filtered sample
// against a bit-exact fixed-point filter kept inside the bench.
// ----------------------------------------------------------------------------
module tb_biquad_highpass_filter
    import bhf_pkg::*;
();

    localparam int FRAC = DEF_COEF_FRAC_BITS;
    localparam int STW  = DEF_STATE_WIDTH;

    typedef logic signed [63:0] wide_t;

    localparam wide_t STATE_MAX = {{(65-STW){1'b0}}, {(STW-1){1'b1}}};
    localparam wide_t STATE_MIN = -STATE_MAX - 64'sd1;
    localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
    localparam coef_t COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;

    // Kinds of coefficient sets loaded between phases.
    typedef enum int { COEFS_RESET, COEFS_NEAR, COEFS_WILD } coef_mix_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;
    logic              cfg_wen;
    cfg_index_t        cfg_index;
    logic [COEF_W-1:0] cfg_data;

    // Filter state and coefficients as the bench predicts them.
    coef_set_t coefs;
    wide_t     state_one;
    wide_t     state_two;

    out_item_t filtered_q[$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_idle_pct  = 0;
    int        hold_left      = 0;

    biquad_highpass_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Signed 64-bit sum that sticks at the ends of the range.
    function automatic wide_t add_sat64(wide_t a, wide_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({2'b00, {63{1'b1}}}))
        begin
            return {1'b0, {63{1'b1}}};
        end
        if (s < $signed({2'b11, {63{1'b0}}}))
        begin
            return {1'b1, {63{1'b0}}};
        end
        return s[63:0];
    endfunction

    // Limits a value to the signed range of a delay state.
    function automatic wide_t clamp_state(wide_t v);
        if (v > STATE_MAX)
        begin
            return STATE_MAX;
        end
        if (v < STATE_MIN)
        begin
            return STATE_MIN;
        end
        return v;
    endfunction

    // Coefficient times state value, rounded half away from zero back to
    // FRAC fraction bits, with the magnitude capped at 2^63-1.
    function automatic wide_t scale_round(coef_t c, wide_t y);
        wide_t        cw;
        logic [63:0]  ua;
        logic [63:0]  uy;
        logic [127:0] q;
        logic         neg;
        wide_t        mag;
        cw  = c;
        neg = cw[63] ^ y[63];
        ua  = cw[63] ? -cw : cw;
        uy  = y[63] ? -y : y;
        q   = ({64'd0, ua} * {64'd0, uy} + (128'd1 << (FRAC - 1))) >> FRAC;
        mag = (q > {65'd0, {63{1'b1}}}) ? {1'b0, {63{1'b1}}} : q[63:0];
        return neg ? -mag : mag;
    endfunction

    // One sample through the transposed direct form II section.
    function automatic out_item_t filter_sample(in_item_t item);
        wide_t       x;
        wide_t       y;
        wide_t       n1;
        wide_t       n2;
        logic [63:0] ymag;
        logic [63:0] r;
        logic        neg;
        out_item_t   res;
        if (item.clear_first)
        begin
            state_one = '0;
            state_two = '0;
        end
        x  = $signed(item.sample_in);
        y  = clamp_state(add_sat64(wide_t'(coefs.b0) * x, state_one));
        n1 = clamp_state(add_sat64(add_sat64(wide_t'(coefs.b1) * x,
                                             -scale_round(coefs.a1, y)), state_two));
        n2 = clamp_state(add_sat64(wide_t'(coefs.b2) * x, -scale_round(coefs.a2, y)));
        state_one = n1;
        state_two = n2;

        // Round to an integer sample and saturate to 16 bits.
        neg  = y[63];
        ymag = neg ? -y : y;
        r    = (ymag + (64'd1 << (FRAC - 1))) >> FRAC;
        res.clipped = 1'b0;
        if (!neg && r > 64'd32767)
        begin
            res.sample_out = PCM_MAX;
            res.clipped    = 1'b1;
        end
        else if (neg && r > 64'd32768)
        begin
            res.sample_out = PCM_MIN;
            res.clipped    = 1'b1;
        end
        else
        begin
            res.sample_out = neg ? -r[SAMPLE_W-1:0] : r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // Offers one item, waits for it to be taken and records its result.
    task automatic send_sample(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        filtered_q.push_back(filter_sample(item));
        @(negedge clk);
    endtask

    // Stops offering items and waits until every result has been taken.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Writes one register and mirrors it into the predicted coefficients.
    task automatic write_coef(input cfg_index_t idx, input coef_t value);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_COEF_B0: coefs.b0 = value;
            REG_COEF_B1: coefs.b1 = value;
            REG_COEF_B2: coefs.b2 = value;
            REG_COEF_A1: coefs.a1 = value;
            REG_COEF_A2: coefs.a2 = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic write_all(input coef_t b0, input coef_t b1, input coef_t b2,
                             input coef_t a1, input coef_t a2);
        write_coef(REG_COEF_B0, b0);
        write_coef(REG_COEF_B1, b1);
        write_coef(REG_COEF_B2, b2);
        write_coef(REG_COEF_A1, a1);
        write_coef(REG_COEF_A2, a2);
    endtask

    // A coefficient at one end of its range, or anywhere in between.
    function automatic coef_t wild_coef();
        case ($urandom_range(0, 3))
            0: return COEF_MIN;
            1: return COEF_MAX;
            default: return coef_t'($urandom);
        endcase
    endfunction

    // Small random offset around a default coefficient, about 5e-4 at most.
    function automatic coef_t near_coef(coef_t base);
        int off;
        off = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        return base + coef_t'(off);
    endfunction

    task automatic load_coefs(input coef_mix_t mix);
        case (mix)
            COEFS_RESET:
                write_all(RST_COEF_B0, RST_COEF_B1, RST_COEF_B2, RST_COEF_A1, RST_COEF_A2);
            COEFS_NEAR:
                write_all(near_coef(RST_COEF_B0), near_coef(RST_COEF_B1),
                          near_coef(RST_COEF_B2), near_coef(RST_COEF_A1),
                          near_coef(RST_COEF_A2));
            default:
                write_all(wild_coef(), wild_coef(), wild_coef(), wild_coef(), wild_coef());
        endcase
    endtask

    // Mostly full-range samples, some small ones, some at the rails.
    function automatic in_item_t random_item();
        in_item_t it;
        case ($urandom_range(0, 9))
            0: it.sample_in = $urandom_range(0, 1) ? PCM_MAX : PCM_MIN;
            1, 2, 3: it.sample_in = 16'($urandom_range(0, 600)) - 16'sd300;
            default: it.sample_in = 16'($urandom);
        endcase
        it.clear_first = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    // Default high-pass after reset: rails, steps, sign flips and clears.
    task automatic test_reset_response();
        recv_idle_pct = 25;
        send_sample('{16'sd0, 1'b1});
        send_sample('{PCM_MAX, 1'b0});
        send_sample('{PCM_MAX, 1'b0});
        send_sample('{PCM_MIN, 1'b0});
        send_sample('{PCM_MIN, 1'b0});
        send_sample('{PCM_MAX, 1'b0});
        send_sample('{16'sd1, 1'b0});
        send_sample('{-16'sd1, 1'b0});
        send_sample('{16'sd100, 1'b1});
        wait_idle();
    endtask

    // Gain of nearly two drives the rounded output past both rails.
    task automatic test_output_saturation();
        write_all(COEF_MAX, '0, '0, '0, '0);
        send_sample('{PCM_MAX, 1'b1});
        send_sample('{PCM_MIN, 1'b0});
        send_sample('{16'sd16383, 1'b0});
        send_sample('{-16'sd16384, 1'b0});
        wait_idle();
        write_coef(REG_COEF_B0, COEF_MIN);
        send_sample('{PCM_MIN, 1'b0});
        send_sample('{PCM_MAX, 1'b0});
        wait_idle();
    endtask

    // Extreme feedback pushes both delay states into their limits; writes
    // to the unused register indexes must change nothing.
    task automatic test_state_saturation();
        write_all(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        for (int i = int'(REG_COEF_A2) + 1; i < (1 << CFG_INDEX_W); i++)
        begin
            write_coef(cfg_index_t'(i), coef_t'($urandom));
        end
        repeat (4) send_sample('{PCM_MAX, 1'b0});
        repeat (2) send_sample('{PCM_MIN, 1'b0});
        send_sample('{16'sd3, 1'b1});
        wait_idle();
    endtask

    // The receiver holds off while items keep coming, so the filter fills
    // and stalls its input; then the sender pauses until all is drained.
    task automatic test_backpressure();
        load_coefs(COEFS_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 300;
        repeat (40) send_sample(random_item());
        wait_idle();
        repeat (10) send_sample(random_item());
        wait_idle();
    endtask

    // Three idling patterns, two coefficient sets in each.
    task automatic test_random_traffic();
        coef_mix_t mixes[6];
        mixes = '{COEFS_NEAR, COEFS_WILD, COEFS_RESET, COEFS_NEAR, COEFS_WILD, COEFS_NEAR};
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 15; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                wait_idle();
                load_coefs(mixes[mode * 2 + half]);
                repeat (175) send_sample(random_item());
            end
        end
        wait_idle();
    endtask

    // Output side: random stalls, or a counted hold-off when one is asked.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Compares every item taken from the output with the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: unexpected output item, sample_out %0d clipped %0b",
                             $realtime, out_data.sample_out, out_data.clipped);
                end
            end
            else
            begin
                want = filtered_q.pop_front();
                if (out_data.sample_out !== want.sample_out ||
                    out_data.clipped !== want.clipped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch: expected sample_out %0d clipped %0b, got %0d %0b",
                                 $realtime, want.sample_out, want.clipped,
                                 out_data.sample_out, out_data.clipped);
                    end
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("[biquad_highpass_filter] ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wen   = 1'b0;
        cfg_index = REG_COEF_B0;
        cfg_data  = '0;
        coefs     = '{RST_COEF_B0, RST_COEF_B1, RST_COEF_B2, RST_COEF_A1, RST_COEF_A2};
        state_one = '0;
        state_two = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_response();
        test_output_saturation();
        test_state_saturation();
        test_backpressure();
        test_random_traffic();

        // Let a stray late item show up before the verdict.
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[biquad_highpass_filter] OK");
        end
        else
        begin
            $display("[biquad_highpass_filter] ERROR");
        end
        $finish;
    end

endmodule
